### hdl/scalar_to_rgb_colormap_core_macros.svh
// Assertion macros shared by the colour map RTL.
`ifndef SCALAR_TO_RGB_COLORMAP_CORE_MACROS_SVH
`define SCALAR_TO_RGB_COLORMAP_CORE_MACROS_SVH
`ifndef SYNTH
`define SCRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCRGB_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`else
`define SCRGB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCRGB_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

### hdl/scrgb_pkg.sv
// Shared types and constants of the scalar to RGB colour map.
package scrgb_pkg;

    localparam int LEVEL_W = 24;
    localparam int CFG_W   = 17;
    localparam int PIX_W   = 8;

    typedef enum logic [1:0] {
        CFG_MAP_MODE   = 2'd0,
        CFG_SATURATION = 2'd1,
        CFG_BRIGHTNESS = 2'd2
    } t_cfg_idx;

    localparam logic             MODE_RESET = 1'b1;
    localparam logic [CFG_W-1:0] SAT_RESET  = 17'd52429;
    localparam logic [CFG_W-1:0] BRI_RESET  = 17'd45875;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = 2;

    typedef logic [2:0] t_sector;

    typedef struct packed {
        logic    gray;
        logic    black;
        t_sector sector;
    } t_cls;

    typedef logic [1:0] t_pick [6][3];

    localparam t_pick SECTOR_PICK = '{
        '{2'd0, 2'd3, 2'd1},
        '{2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd3},
        '{2'd1, 2'd2, 2'd0},
        '{2'd3, 2'd1, 2'd0},
        '{2'd0, 2'd1, 2'd2}
    };

endpackage

### hdl/scrgb_channels_if.sv
// Request channels of the colour map: scalar in, pixel out.
interface scrgb_level_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [scrgb_pkg::LEVEL_W-1:0]     level;
    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface scrgb_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [scrgb_pkg::PIX_W-1:0]      red;
    logic [scrgb_pkg::PIX_W-1:0]      green;
    logic [scrgb_pkg::PIX_W-1:0]      blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### hdl/scalar_to_rgb_colormap_core.sv
// Top level of the scalar to sRGB colour map.
// Maps one signed scalar (FRAC_BITS fraction bits) per request to an 8-bit sRGB pixel,
// in grayscale or HSV rainbow mode. It takes one request every clock cycle and
// delivers one pixel per cycle unless stalled, through 1 front stage, the four-entry
// queue, 3 HSV stages, 8 threshold-search stages and the output register.
// Sustained rate is set by the pixel port: a stalled output holds the whole colour
// pipeline while the queue absorbs up to four more requests. The sRGB threshold table
// is computed at elaboration; there is no warm-up after reset. Configuration is written
// through i_cfg_we/i_cfg_idx/i_cfg_data, by the user only while idle; not enforced.
module scalar_to_rgb_colormap_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    scrgb_level_if.sink                 i_level,
    scrgb_pixel_if.source               o_pixel,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [scrgb_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int XW = FRAC_BITS + 1;
    localparam int QW = $bits(scrgb_pkg::t_cls) + XW;

    logic                        r_map_mode;
    logic [scrgb_pkg::CFG_W-1:0] r_sat;
    logic [scrgb_pkg::CFG_W-1:0] r_bri;

    logic            push;
    logic            full;
    logic            empty;
    logic            pop;
    logic            en;
    scrgb_pkg::t_cls f_cls;
    logic [XW-1:0]   f_xf;
    logic [QW-1:0]   q_out;
    scrgb_pkg::t_cls q_cls;
    logic [XW-1:0]   q_xf;
    logic            h_vld;
    logic            h_blk;
    logic [XW-1:0]   h_x [0:2];
    logic            g_vld;
    logic [7:0]      g_byte [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode <= scrgb_pkg::MODE_RESET;
            r_sat      <= scrgb_pkg::SAT_RESET;
            r_bri      <= scrgb_pkg::BRI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scrgb_pkg::CFG_MAP_MODE:   r_map_mode <= i_cfg_data[0];
                scrgb_pkg::CFG_SATURATION: r_sat      <= i_cfg_data;
                scrgb_pkg::CFG_BRIGHTNESS: r_bri      <= i_cfg_data;
                default:                   ;
            endcase
        end
    end

    scrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_level.valid),
        .o_ready    (i_level.ready),
        .i_level    (i_level.level),
        .i_map_mode (r_map_mode),
        .i_full     (full),
        .o_push     (push),
        .o_cls      (f_cls),
        .o_xf       (f_xf)
    );

    scrgb_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cls, f_xf}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign q_cls = q_out[QW-1:XW];
    assign q_xf  = q_out[XW-1:0];
    assign en    = !g_vld || o_pixel.ready;
    assign pop   = en && !empty;

    scrgb_hsv #(.FRAC_BITS(FRAC_BITS)) u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (!empty),
        .i_cls   (q_cls),
        .i_xf    (q_xf),
        .i_sat   (r_sat),
        .i_bri   (r_bri),
        .o_vld   (h_vld),
        .o_blk   (h_blk),
        .o_x     (h_x)
    );

    scrgb_gamma #(.FRAC_BITS(FRAC_BITS)) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (h_vld),
        .i_blk   (h_blk),
        .i_x     (h_x),
        .o_vld   (g_vld),
        .o_byte  (g_byte)
    );

    assign o_pixel.valid = g_vld;
    assign o_pixel.red   = g_byte[0];
    assign o_pixel.green = g_byte[1];
    assign o_pixel.blue  = g_byte[2];

endmodule

### hdl/scrgb_front.sv
// Front stage: takes requests, classifies them, gets sector and hue fraction or grey.
module scrgb_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [scrgb_pkg::LEVEL_W-1:0] i_level,
    input  logic                              i_map_mode,
    input  logic                              i_full,
    output logic                              o_push,
    output scrgb_pkg::t_cls                   o_cls,
    output logic [FRAC_BITS:0]                o_xf
);
    localparam int XW = FRAC_BITS + 1;
    localparam int NW = 26 - FRAC_BITS;
    localparam int CW = (XW > 23) ? XW : 23;
    localparam int MOD6_SH = 21;
    localparam logic [18:0] MOD6_MUL = 19'd349526;

    logic            r_vld;
    scrgb_pkg::t_cls r_cls;
    logic [XW-1:0]   r_xf;

    logic [22:0]     mag;
    logic            neg;
    logic [25:0]     h6;
    logic [NW-1:0]   hint;
    logic [NW+18:0]  prod;
    logic [NW-1:0]   quo;
    logic [NW+2:0]   rem;
    logic [CW-1:0]   mag_c;
    logic [XW-1:0]   gray_x;
    scrgb_pkg::t_cls n_cls;
    logic [XW-1:0]   n_xf;

    always_comb begin
        mag   = i_level[22:0];
        neg   = i_level[23];
        h6    = (26'(mag) << 2) + (26'(mag) << 1);
        hint  = h6[25:FRAC_BITS];
        // sector = integer part of 6*level modulo 6, by reciprocal multiply
        prod  = (NW+19)'(hint) * (NW+19)'(MOD6_MUL);
        quo   = NW'(prod >> MOD6_SH);
        rem   = (NW+3)'(hint) - ((NW+3)'(quo) << 2) - ((NW+3)'(quo) << 1);
        mag_c = CW'(mag);
        if (neg) begin
            gray_x = '0;
        end else if (mag_c > (CW'(1) << FRAC_BITS)) begin
            gray_x = XW'(1) << FRAC_BITS;
        end else begin
            gray_x = XW'(mag_c);
        end
        n_cls.gray   = !i_map_mode;
        n_cls.black  = i_map_mode && (neg || (mag == 23'd0));
        n_cls.sector = rem[2:0];
        n_xf = n_cls.gray ? gray_x : {1'b0, h6[FRAC_BITS-1:0]};
    end

    assign o_ready = !r_vld || !i_full;
    assign o_push  = r_vld && !i_full;
    assign o_cls   = r_cls;
    assign o_xf    = r_xf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
            r_xf  <= n_xf;
        end
    end

endmodule

### hdl/scrgb_fifo.sv
// Short queue between the front stage and the colour pipeline.
`include "scalar_to_rgb_colormap_core_macros.svh"
module scrgb_fifo #(
    parameter int W = 22
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int QAW = scrgb_pkg::QAW;

    logic [W-1:0] r_mem [scrgb_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(scrgb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SCRGB_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `SCRGB_ASSERT_IMP(a_count_up, i_clk, i_rst_n, i_push && !i_pop, ##1 r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

### hdl/scrgb_hsv.sv
// HSV to linear RGB pipeline: products of saturation and brightness, sector selection.
`include "scalar_to_rgb_colormap_core_macros.svh"
module scrgb_hsv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  scrgb_pkg::t_cls                 i_cls,
    input  logic [FRAC_BITS:0]              i_xf,
    input  logic [scrgb_pkg::CFG_W-1:0]     i_sat,
    input  logic [scrgb_pkg::CFG_W-1:0]     i_bri,
    output logic                            o_vld,
    output logic                            o_blk,
    output logic [FRAC_BITS:0]              o_x [0:2]
);
    localparam int XW = FRAC_BITS + 1;
    localparam int PW = 2 * XW;
    localparam logic [XW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [XW-1:0] to_frac(input logic [scrgb_pkg::CFG_W-1:0] r);
        logic [40:0] w;
        w = {r, 24'b0} >> (40 - FRAC_BITS);
        return (w > (41'(1) << FRAC_BITS)) ? ONE : XW'(w);
    endfunction

    function automatic logic [XW-1:0] pick(input logic [1:0] sel, input logic [XW-1:0] c0,
                                           input logic [XW-1:0] c1, input logic [XW-1:0] c2,
                                           input logic [XW-1:0] c3);
        logic [XW-1:0] res;
        case (sel)
            2'd0:    res = c0;
            2'd1:    res = c1;
            2'd2:    res = c2;
            default: res = c3;
        endcase
        return res;
    endfunction

    // stage 1
    logic [XW-1:0] s_f, v_f, one_mf, sf, sg;
    logic [PW-1:0] p_sf, p_sg;
    logic            r1_vld;
    scrgb_pkg::t_cls r1_cls;
    logic [XW-1:0]   r1_x, r1_v, r1_s, r1_sf, r1_sg;
    // stage 2
    logic [PW-1:0]   p_c1, p_c2, p_c3;
    logic            r2_vld;
    scrgb_pkg::t_cls r2_cls;
    logic [XW-1:0]   r2_x, r2_c0, r2_c1, r2_c2, r2_c3;
    // stage 3
    logic [XW-1:0]   n_x [0:2];
    logic            r3_vld;
    logic            r3_blk;
    logic            r3_gray;
    logic [XW-1:0]   r3_x [0:2];

    always_comb begin
        s_f    = to_frac(i_sat);
        v_f    = to_frac(i_bri);
        one_mf = ONE - {1'b0, i_xf[FRAC_BITS-1:0]};
        p_sf   = PW'(s_f) * PW'(i_xf[FRAC_BITS-1:0]);
        p_sg   = PW'(s_f) * PW'(one_mf);
        sf     = p_sf[FRAC_BITS +: XW];
        sg     = p_sg[FRAC_BITS +: XW];
    end

    always_comb begin
        p_c1 = PW'(r1_v) * PW'(ONE - r1_s);
        p_c2 = PW'(r1_v) * PW'(ONE - r1_sf);
        p_c3 = PW'(r1_v) * PW'(ONE - r1_sg);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r2_cls.gray) begin
                n_x[k] = r2_x;
            end else if (r2_cls.sector > 3'd5) begin
                n_x[k] = '0;
            end else begin
                n_x[k] = pick(scrgb_pkg::SECTOR_PICK[r2_cls.sector][k],
                              r2_c0, r2_c1, r2_c2, r2_c3);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cls  <= i_cls;
            r1_x    <= i_xf;
            r1_v    <= v_f;
            r1_s    <= s_f;
            r1_sf   <= sf;
            r1_sg   <= sg;
            r2_cls  <= r1_cls;
            r2_x    <= r1_x;
            r2_c0   <= r1_v;
            r2_c1   <= p_c1[FRAC_BITS +: XW];
            r2_c2   <= p_c2[FRAC_BITS +: XW];
            r2_c3   <= p_c3[FRAC_BITS +: XW];
            r3_blk  <= r2_cls.black;
            r3_gray <= r2_cls.gray;
            for (int k = 0; k < 3; k++) begin
                r3_x[k] <= n_x[k];
            end
        end
    end

    assign o_vld = r3_vld;
    assign o_blk = r3_blk;
    assign o_x   = r3_x;

    `SCRGB_ASSERT_IMP(a_chan_le_v, i_clk, i_rst_n, r2_vld, r2_c1 <= r2_c0 && r2_c2 <= r2_c0 && r2_c3 <= r2_c0, "channel above brightness")
    `SCRGB_ASSERT_IMP(a_gray_equal, i_clk, i_rst_n, r3_vld && r3_gray, r3_x[0] == r3_x[1] && r3_x[1] == r3_x[2], "grayscale lanes differ")

endmodule

### hdl/scrgb_gamma.sv
// sRGB encoder: three lanes of threshold search over a table built at elaboration.
`include "scalar_to_rgb_colormap_core_macros.svh"
module scrgb_gamma #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic                          i_blk,
    input  logic [FRAC_BITS:0]            i_x [0:2],
    output logic                          o_vld,
    output logic [scrgb_pkg::PIX_W-1:0]   o_byte [0:2]
);
    localparam int XW = FRAC_BITS + 1;
    localparam int SW = XW + 17;
    localparam longint unsigned LIN_LIM =
        (64'd31308 * (64'd1 << FRAC_BITS) + 64'd9999999) / 64'd10000000;

    // smallest x reaching each byte on the power segment of the sRGB curve
    function automatic logic [256*XW-1:0] gen_thr();
        logic [256*XW-1:0] tab;
        logic [319:0]      d12;
        logic [319:0]      rhs;
        logic [319:0]      lhs;
        longint            lo;
        longint            hi;
        longint            mid;
        tab = '0;
        d12 = 320'd1;
        for (int i = 0; i < 12; i++) begin
            d12 = d12 * 320'd10761;
        end
        for (int b = 1; b < 256; b++) begin
            rhs = 320'd1;
            for (int i = 0; i < 12; i++) begin
                rhs = rhs * 320'(40 * b + 541);
            end
            rhs = rhs << (5 * FRAC_BITS);
            lo = 0;
            hi = (64'sd1 << FRAC_BITS) + 1;
            for (int it = 0; it < FRAC_BITS + 3; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >>> 1;
                    lhs = 320'd1;
                    for (int i = 0; i < 5; i++) begin
                        lhs = lhs * 320'(mid);
                    end
                    lhs = lhs * d12;
                    if (lhs >= rhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            tab[b*XW +: XW] = XW'(lo);
        end
        return tab;
    endfunction

    localparam logic [256*XW-1:0] THR = gen_thr();

    logic          r_vld   [0:7];
    logic          r_blk   [0:7];
    logic [XW-1:0] r_x     [0:7][0:2];
    logic [7:0]    r_acc   [0:7][0:2];
    logic          r_islin [0:7][0:2];
    logic [6:0]    r_q     [0:2];
    logic [3:0]    r_lin   [1:7][0:2];
    logic [7:0]    n_acc   [0:7][0:2];
    logic [SW-1:0] lsum    [0:2];
    logic [14:0]   lmul    [0:2];
    logic          r_ovld;
    logic [7:0]    r_byte  [0:2];

    genvar s, k;
    for (s = 0; s < 8; s++) begin : g_stage
        localparam logic [7:0] STEP = 8'd1 << (7 - s);
        for (k = 0; k < 3; k++) begin : g_lane
            logic [XW-1:0] px;
            logic [7:0]    pacc;
            logic [7:0]    cand;
            if (s == 0) begin : g_first
                assign px   = i_x[k];
                assign pacc = '0;
            end else begin : g_next
                assign px   = r_x[s-1][k];
                assign pacc = r_acc[s-1][k];
            end
            assign cand = pacc | STEP;
            assign n_acc[s][k] = (THR[cand*XW +: XW] <= px) ? cand : pacc;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lsum[j] = SW'(i_x[j]) * SW'(32946) + (SW'(5) << FRAC_BITS);
            lmul[j] = 15'(r_q[j]) * 15'd205;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < 8; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_ovld <= r_vld[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk[0] <= i_blk;
            for (int j = 1; j < 8; j++) begin
                r_blk[j] <= r_blk[j-1];
            end
            for (int l = 0; l < 3; l++) begin
                r_x[0][l]     <= i_x[l];
                r_acc[0][l]   <= n_acc[0][l];
                r_islin[0][l] <= (64'(i_x[l]) < LIN_LIM);
                r_q[l]        <= lsum[l][FRAC_BITS +: 7];
                r_lin[1][l]   <= lmul[l][14:11];
                for (int j = 1; j < 8; j++) begin
                    r_x[j][l]     <= r_x[j-1][l];
                    r_acc[j][l]   <= n_acc[j][l];
                    r_islin[j][l] <= r_islin[j-1][l];
                end
                for (int j = 2; j < 8; j++) begin
                    r_lin[j][l] <= r_lin[j-1][l];
                end
                if (r_blk[7]) begin
                    r_byte[l] <= '0;
                end else if (r_islin[7][l]) begin
                    r_byte[l] <= {4'b0, r_lin[7][l]};
                end else begin
                    r_byte[l] <= r_acc[7][l];
                end
            end
        end
    end

    assign o_vld  = r_ovld;
    assign o_byte = r_byte;

    `SCRGB_ASSERT_IMP(a_lin_small, i_clk, i_rst_n, r_vld[7] && r_islin[7][0], r_lin[7][0] <= 4'd10, "linear segment byte too large")
    `SCRGB_ASSERT_IMP(a_black_out, i_clk, i_rst_n, i_en && r_vld[7] && r_blk[7], ##1 r_byte[0] == '0 && r_byte[1] == '0 && r_byte[2] == '0, "black pixel not zero")

endmodule

### dv/tb_scalar_to_rgb_colormap_core.sv
// Self-checking testbench for scalar_to_rgb_colormap_core: predicted sRGB pixels vs DUT output.
`timescale 1ns / 100ps

module tb_scalar_to_rgb_colormap_core;
    import scrgb_pkg::*;

    localparam longint unsigned ONE = 64'd65536;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF = 400;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 165;
    localparam int MAX_REPORTS = 40;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // which of v, p, q, t feeds red, green and blue in each hue sector
    localparam int CHANNEL_SOURCE [6][3] = '{
        '{0, 3, 1}, '{2, 0, 1}, '{1, 0, 3}, '{1, 2, 0}, '{3, 1, 0}, '{0, 1, 2}
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
    } t_pixel_exp;

    class srgb_pixel_predictor;
        logic             mode;
        logic [CFG_W-1:0] sat;
        logic [CFG_W-1:0] bri;
        logic [319:0]     den12;
        logic [319:0]     byte_floor [256];
        t_pixel_exp       pending_pixels [$];
        int               mismatches;
        int               pixels_seen;

        function new();
            logic [319:0] p;
            int b;
            den12 = 320'd1;
            repeat (12) den12 = den12 * 320'd10761;
            byte_floor[0] = '0;
            for (b = 1; b < 256; b++) begin
                p = 320'd1;
                repeat (12) p = p * 320'(40 * b + 541);
                byte_floor[b] = p << 80;
            end
            mode = MODE_RESET;
            sat = SAT_RESET;
            bri = BRI_RESET;
            mismatches = 0;
            pixels_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MAP_MODE: mode = data[0];
                CFG_SATURATION: sat = data;
                CFG_BRIGHTNESS: bri = data;
                default: ;
            endcase
        endfunction

        // exact sRGB curve, nearest byte: largest b with x^5*10761^12 >= (40b+541)^12*2^80
        function logic [PIX_W-1:0] srgb_encode(longint unsigned x);
            logic [319:0] acc;
            int lo, hi, mid;
            if (x > ONE) x = ONE;
            if (x * 64'd10000000 < 64'd31308 * ONE)
                return PIX_W'((x * 64'd32946 + 64'd5 * ONE) / (64'd10 * ONE));
            acc = 320'(x);
            repeat (4) acc = acc * 320'(x);
            acc = acc * den12;
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (acc >= byte_floor[mid]) lo = mid;
                else hi = mid - 1;
            end
            return PIX_W'(lo);
        endfunction

        function void take_level(logic [LEVEL_W-1:0] lv);
            t_pixel_exp px;
            longint unsigned mag, s, v, h6, f, sf, sg;
            longint unsigned chan [4];
            int sector;
            mag = 64'(lv);
            px.level = lv;
            if (!mode) begin
                px.red = srgb_encode(lv[LEVEL_W-1] ? 64'd0 : mag);
                px.green = px.red;
                px.blue = px.red;
            end else if (lv[LEVEL_W-1] || mag == 0) begin
                px.red = '0;
                px.green = '0;
                px.blue = '0;
            end else begin
                s = (64'(sat) > ONE) ? ONE : 64'(sat);
                v = (64'(bri) > ONE) ? ONE : 64'(bri);
                h6 = mag * 6;
                f = h6 & (ONE - 1);
                sector = int'((h6 >> 16) % 6);
                sf = (s * f) >> 16;
                sg = (s * (ONE - f)) >> 16;
                chan[0] = v;
                chan[1] = (v * (ONE - s)) >> 16;
                chan[2] = (v * (ONE - sf)) >> 16;
                chan[3] = (v * (ONE - sg)) >> 16;
                px.red = srgb_encode(chan[CHANNEL_SOURCE[sector][0]]);
                px.green = srgb_encode(chan[CHANNEL_SOURCE[sector][1]]);
                px.blue = srgb_encode(chan[CHANNEL_SOURCE[sector][2]]);
            end
            pending_pixels.push_back(px);
        endfunction

        function void flag(string field, logic [LEVEL_W-1:0] lv,
                           logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: level %06h %s expected %02h actual %02h",
                         $time, lv, field, want, got);
        endfunction

        function void match_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                  logic [PIX_W-1:0] b);
            t_pixel_exp px;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: pixel %02h %02h %02h with no request outstanding",
                         $time, r, g, b);
                return;
            end
            px = pending_pixels.pop_front();
            pixels_seen++;
            if (r !== px.red) flag("red", px.level, px.red, r);
            if (g !== px.green) flag("green", px.level, px.green, g);
            if (b !== px.blue) flag("blue", px.level, px.blue, b);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    scrgb_level_if lvl_if ();
    scrgb_pixel_if pix_if ();

    scalar_to_rgb_colormap_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_level    (lvl_if),
        .o_pixel    (pix_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    srgb_pixel_predictor predictor = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int levels_sent = 0;
    int settings_used = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pix_if.ready <= 1'b0;
        end else begin
            pix_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            predictor.match_pixel(pix_if.red, pix_if.green, pix_if.blue);
    end

    always @(posedge i_clk) begin
        if ((lvl_if.valid && lvl_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("** scalar_to_rgb_colormap_core: FAILED **");
            $finish;
        end
    end

    task automatic send_level(input logic [LEVEL_W-1:0] lv);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            lvl_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        lvl_if.valid <= 1'b1;
        lvl_if.level <= lv;
        @(posedge i_clk);
        while (!lvl_if.ready) @(posedge i_clk);
        predictor.take_level(lv);
        levels_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        lvl_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (predictor.pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] mode_data, input logic [CFG_W-1:0] sat_data,
                              input logic [CFG_W-1:0] bri_data, input bit poke_unused);
        logic [1:0]       idx [4];
        logic [CFG_W-1:0] dat [4];
        int k, n;
        idx = '{CFG_MAP_MODE, CFG_SATURATION, CFG_BRIGHTNESS, CFG_UNUSED};
        dat = '{mode_data, sat_data, bri_data, CFG_W'($urandom)};
        n = poke_unused ? 4 : 3;
        for (k = 0; k < n; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_data <= dat[k];
            @(posedge i_clk);
            predictor.write_reg(idx[k], dat[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    localparam logic [LEVEL_W-1:0] HUE_POINTS [13] = '{
        24'h000000, 24'h000001, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
        24'd5461, 24'd10923, 24'd21846, 24'd32768, 24'd43691,
        24'd54613, 24'd65535, 24'd65536
    };
    localparam logic [LEVEL_W-1:0] GREY_POINTS [9] = '{
        24'hFFFFFF, 24'h000000, 24'd205, 24'd206, 24'd65535,
        24'd65536, 24'd65537, 24'h7FFFFF, 24'h800000
    };

    initial begin
        logic [CFG_W-1:0] mode_data, sat_data, bri_data;
        logic [LEVEL_W-1:0] lv;
        int phase, i;
        bit poke;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MAP_MODE;
        i_cfg_data = '0;
        lvl_if.valid = 1'b0;
        lvl_if.level = '0;
        pix_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // reset settings: rainbow at 0.8 / 0.7, sector edges and field extremes
        foreach (HUE_POINTS[i]) send_level(HUE_POINTS[i]);
        drop_valid();
        wait_drained();

        // grey map, clamp ends and the linear/power knee
        set_config(17'h1FFFE, 17'h10000, 17'h1FFFF, 1'b1);
        foreach (GREY_POINTS[i]) send_level(GREY_POINTS[i]);
        drop_valid();
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 4) begin
                tx_idle_pct = 35;
                rx_idle_pct = 84;
            end else if (phase < 8) begin
                tx_idle_pct = 84;
                rx_idle_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            mode_data = CFG_W'($urandom);
            sat_data = CFG_W'($urandom_range(0, 65536));
            bri_data = CFG_W'($urandom_range(0, 65536));
            poke = 1'b0;
            case (phase)
                0, 4: mode_data[0] = 1'b0;
                1: begin
                    mode_data[0] = 1'b1;
                    sat_data = '0;
                    bri_data = 17'h10000;
                end
                2: begin
                    mode_data[0] = 1'b1;
                    sat_data = 17'h10000;
                    bri_data = '0;
                end
                3: begin
                    mode_data[0] = 1'b1;
                    sat_data = 17'h1FFFF;
                    bri_data = 17'h1FFFF;
                    poke = 1'b1;
                end
                5: begin
                    mode_data[0] = 1'b1;
                    sat_data = 17'd1;
                    bri_data = 17'd1;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) sat_data = CFG_W'($urandom);
                    if ($urandom_range(0, 3) == 0) bri_data = CFG_W'($urandom);
                    poke = ($urandom_range(0, 1) == 1);
                end
            endcase
            set_config(mode_data, sat_data, bri_data, poke);
            // output held off while the input keeps coming, so the queue fills
            if (phase == 8) hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: lv = LEVEL_W'($urandom);
                    2: lv = LEVEL_W'(-$urandom_range(1, 70000));
                    3: lv = LEVEL_W'($urandom_range(0, 300));
                    4: lv = LEVEL_W'(65528 + $urandom_range(0, 16));
                    5, 6, 7: lv = LEVEL_W'($urandom_range(0, 65536));
                    default: lv = LEVEL_W'($urandom_range(0, 24'h40000));
                endcase
                send_level(lv);
                if (phase == 10 && i == PHASE_ITEMS / 2) begin
                    drop_valid();
                    wait_drained();
                end
            end
            drop_valid();
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        $display("Ran %0d scalars through %0d register settings, grey and rainbow maps,",
                 levels_sent, settings_used);
        $display("%0d pixels checked under both idle patterns and a long output hold-off.",
                 predictor.pixels_seen);
        if (predictor.mismatches == 0 && predictor.pending_pixels.size() == 0) begin
            $display("** scalar_to_rgb_colormap_core: PASSED **");
        end else begin
            $display("** scalar_to_rgb_colormap_core: FAILED **");
        end
        $finish;
    end

endmodule
